// ----- src/pib_pkg.sv -----
// Shared types and constants for the particle integrate-and-bounce unit.
package pib_pkg;

   // Number of axes, one lane each
   localparam int NUM_AXES = 3;

   // Configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIME_STEP     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INVERSE_MASS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXTENT_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXTENT_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXTENT_Z = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WALL_DAMPING  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTEG_MODE    = 3'd6;

   // Register reset values
   localparam logic [16:0] TIME_STEP_RESET    = 17'd655;
   localparam logic [24:0] INVERSE_MASS_RESET = 25'd65536;
   localparam logic [30:0] HALF_EXTENT_RESET  = 31'd655360;
   localparam logic [16:0] WALL_DAMPING_RESET = 17'd52429;
   localparam logic        INTEG_MODE_RESET   = 1'b0;

   // Velocity gain = time_step * inverse_mass / 2^16, 26 bits unsigned
   localparam int GAIN_W = 26;
   localparam longint GAIN_RESET_FULL =
      (longint'(TIME_STEP_RESET) * longint'(INVERSE_MASS_RESET)) >> 16;
   localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(GAIN_RESET_FULL);

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic               last_in_frame;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_pos_x;
      logic signed [31:0] new_pos_y;
      logic signed [31:0] new_pos_z;
      logic signed [31:0] new_vel_x;
      logic signed [31:0] new_vel_y;
      logic signed [31:0] new_vel_z;
      logic [2:0]         wall_hits;
      logic               frame_end;
   } rsp_type;

   // Settings shared by all lanes
   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [16:0]       time_step;
      logic [16:0]       wall_damping;
      logic              integration_mode;
   } lane_cfg_type;

   // What one lane produces
   typedef struct packed {
      logic signed [31:0] new_pos;
      logic signed [31:0] new_vel;
      logic               hit;
   } lane_out_type;

   // Request tracking along the pipeline
   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

   // Saturate a signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// ----- src/pib_lane.sv -----
// One axis: Euler step, saturation and wall reflection, five register stages.
module pib_lane (
   input  logic                 clock,
   input  pib_pkg::lane_cfg_type cfg,
   input  logic [30:0]          half_extent,
   input  logic signed [31:0]   pos,
   input  logic signed [31:0]   vel,
   input  logic signed [31:0]   force_val,
   output pib_pkg::lane_out_type result
);
   import pib_pkg::*;

   // Stage B: force times gain
   logic signed [58:0] fg_in, fg_ff;
   logic signed [31:0] p_b_ff, v_b_ff;

   assign fg_in = force_val * $signed({1'b0, cfg.gain});

   always_ff @(posedge clock) begin
      fg_ff  <= fg_in;
      p_b_ff <= pos;
      v_b_ff <= vel;
   end

   // Stage C: new velocity, pick the velocity that moves the position
   logic signed [42:0] fg_sh;
   logic signed [43:0] vsum;
   logic signed [31:0] nv_in, mv_in;
   logic signed [31:0] nv_c_ff, mv_c_ff, p_c_ff;

   assign fg_sh = fg_ff[58:16];
   assign vsum  = {{12{v_b_ff[31]}}, v_b_ff} + {fg_sh[42], fg_sh};
   assign nv_in = sat32(64'(vsum));
   assign mv_in = cfg.integration_mode ? nv_in : v_b_ff;

   always_ff @(posedge clock) begin
      nv_c_ff <= nv_in;
      mv_c_ff <= mv_in;
      p_c_ff  <= p_b_ff;
   end

   // Stage D: move times step, velocity times damping
   logic signed [49:0] mt_in, nd_in, mt_ff, nd_ff;
   logic signed [31:0] nv_d_ff, p_d_ff;

   assign mt_in = mv_c_ff * $signed({1'b0, cfg.time_step});
   assign nd_in = nv_c_ff * $signed({1'b0, cfg.wall_damping});

   always_ff @(posedge clock) begin
      mt_ff   <= mt_in;
      nd_ff   <= nd_in;
      nv_d_ff <= nv_c_ff;
      p_d_ff  <= p_c_ff;
   end

   // Stage E: new position and reflected velocity, both saturated
   logic signed [33:0] mt_sh;
   logic signed [34:0] psum;
   logic signed [50:0] nd_neg;
   logic signed [34:0] refl_sh;
   logic signed [31:0] pos_e_ff, nv_e_ff, refl_e_ff;

   assign mt_sh   = mt_ff[49:16];
   assign psum    = {{3{p_d_ff[31]}}, p_d_ff} + {mt_sh[33], mt_sh};
   assign nd_neg  = -{nd_ff[49], nd_ff};
   assign refl_sh = nd_neg[50:16];

   always_ff @(posedge clock) begin
      pos_e_ff  <= sat32(64'(psum));
      nv_e_ff   <= nv_d_ff;
      refl_e_ff <= sat32(64'(refl_sh));
   end

   // Stage F: wall test and clamp
   logic signed [32:0] h_pos, h_neg, pos_w;
   logic               hit_in;
   lane_out_type       res_in, res_ff;

   assign h_pos  = $signed({2'b00, half_extent});
   assign h_neg  = -h_pos;
   assign pos_w  = {pos_e_ff[31], pos_e_ff};
   assign hit_in = (pos_w <= h_neg) || (pos_w >= h_pos);

   always_comb begin
      res_in.hit     = hit_in;
      res_in.new_pos = pos_e_ff;
      res_in.new_vel = nv_e_ff;
      if (hit_in) begin
         res_in.new_pos = pos_e_ff[31] ? h_neg[31:0] : h_pos[31:0];
         res_in.new_vel = refl_e_ff;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// ----- src/pib_merge.sv -----
// Gathers the three lane results into one response and registers it.
module pib_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  pib_pkg::ctl_type      ctl,
   input  pib_pkg::lane_out_type lane_res [pib_pkg::NUM_AXES],
   output logic                  rsp_valid,
   output pib_pkg::rsp_type      rsp_data
);
   import pib_pkg::*;

   rsp_type rsp_in, rsp_data_ff;
   logic    rsp_valid_ff;

   // Assemble the response from the lanes
   always_comb begin
      rsp_in.new_pos_x = lane_res[0].new_pos;
      rsp_in.new_pos_y = lane_res[1].new_pos;
      rsp_in.new_pos_z = lane_res[2].new_pos;
      rsp_in.new_vel_x = lane_res[0].new_vel;
      rsp_in.new_vel_y = lane_res[1].new_vel;
      rsp_in.new_vel_z = lane_res[2].new_vel;
      rsp_in.wall_hits = {lane_res[2].hit, lane_res[1].hit, lane_res[0].hit};
      rsp_in.frame_end = ctl.last;
   end

   // Output register, strobe cleared under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl.valid;
      end
      rsp_data_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/particle_integrate_and_bounce_unit.sv -----
// Top level of the particle integrate-and-bounce unit.
// Usage:
//   Request channel: drive req_data and raise start; a request is taken at
//   each rising edge with start high and busy low. busy is low except during
//   reset, so one particle can be issued every cycle.
//   Response channel: rsp_valid strobes for one cycle with rsp_data. The
//   receiver cannot stall, so results must be captured on the strobe.
//   Throughput is one particle per cycle while busy is low. A request
//   passes an input register, then the three lanes (x, y, z), each
//   running a five-stage multiply/add/saturate pipe, and a merge
//   register.
//   Configuration: csr_valid/csr_ready with csr_index and csr_data; csr_ready
//   is always high. Write only while no request is in flight.
//   Writes to unknown indexes are ignored.
//   Reset (synchronous, active high) restores the register defaults and
//   drops all requests in flight; no response follows a reset.
module particle_integrate_and_bounce_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  pib_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   output pib_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pib_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                       csr_data
);
   import pib_pkg::*;

   localparam int CTL_DEPTH = 6;

   // Configuration registers
   logic [16:0]       time_step_ff, wall_damping_ff;
   logic [24:0]       inverse_mass_ff;
   logic [30:0]       half_x_ff, half_y_ff, half_z_ff;
   logic              integ_mode_ff;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [41:0]       gain_prod;
   logic              csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff    <= TIME_STEP_RESET;
         inverse_mass_ff <= INVERSE_MASS_RESET;
         half_x_ff       <= HALF_EXTENT_RESET;
         half_y_ff       <= HALF_EXTENT_RESET;
         half_z_ff       <= HALF_EXTENT_RESET;
         wall_damping_ff <= WALL_DAMPING_RESET;
         integ_mode_ff   <= INTEG_MODE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIME_STEP:     time_step_ff    <= csr_data[16:0];
            CSR_INVERSE_MASS:  inverse_mass_ff <= csr_data[24:0];
            CSR_HALF_EXTENT_X: half_x_ff       <= csr_data[30:0];
            CSR_HALF_EXTENT_Y: half_y_ff       <= csr_data[30:0];
            CSR_HALF_EXTENT_Z: half_z_ff       <= csr_data[30:0];
            CSR_WALL_DAMPING:  wall_damping_ff <= csr_data[16:0];
            CSR_INTEG_MODE:    integ_mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Velocity gain, refreshed in the cycle after any register write
   assign gain_prod = 42'(time_step_ff) * 42'(inverse_mass_ff);
   assign gain_in   = gain_prod[41:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else begin
         gain_ff <= gain_in;
      end
   end

   // Request intake
   logic    req_take;
   req_type req_a_ff;
   ctl_type ctl_in;
   ctl_type ctl_ff [CTL_DEPTH];

   assign busy     = reset;
   assign req_take = start && !busy;

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_a_ff <= req_data;
      end
   end

   // Control travels beside the lanes
   assign ctl_in.valid = req_take;
   assign ctl_in.last  = req_data.last_in_frame;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CTL_DEPTH; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < CTL_DEPTH; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   // Lanes
   lane_cfg_type       lane_cfg;
   logic signed [31:0] pos_a   [NUM_AXES];
   logic signed [31:0] vel_a   [NUM_AXES];
   logic signed [31:0] force_a [NUM_AXES];
   logic [30:0]        half_a  [NUM_AXES];
   lane_out_type       lane_res [NUM_AXES];

   assign lane_cfg.gain             = gain_ff;
   assign lane_cfg.time_step        = time_step_ff;
   assign lane_cfg.wall_damping     = wall_damping_ff;
   assign lane_cfg.integration_mode = integ_mode_ff;

   assign pos_a[0]   = req_a_ff.pos_x;
   assign pos_a[1]   = req_a_ff.pos_y;
   assign pos_a[2]   = req_a_ff.pos_z;
   assign vel_a[0]   = req_a_ff.vel_x;
   assign vel_a[1]   = req_a_ff.vel_y;
   assign vel_a[2]   = req_a_ff.vel_z;
   assign force_a[0] = req_a_ff.force_x;
   assign force_a[1] = req_a_ff.force_y;
   assign force_a[2] = req_a_ff.force_z;
   assign half_a[0]  = half_x_ff;
   assign half_a[1]  = half_y_ff;
   assign half_a[2]  = half_z_ff;

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
      pib_lane u_lane (
         .clock       (clock),
         .cfg         (lane_cfg),
         .half_extent (half_a[g]),
         .pos         (pos_a[g]),
         .vel         (vel_a[g]),
         .force_val   (force_a[g]),
         .result      (lane_res[g])
      );
   end

   // Merge and output register
   pib_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_ff[CTL_DEPTH-1]),
      .lane_res  (lane_res),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // Every accepted request yields a strobe once it has passed the pipeline
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_take |=> ##6 rsp_valid)
      else $error("response missing for accepted request");

   // No strobe without an earlier accepted request
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, 7))
      else $error("response without a request");

   // A hit on x leaves the position on a wall
   a_x_hit_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.wall_hits[0]) |->
         (rsp_data.new_pos_x == $signed({1'b0, half_x_ff})) ||
         (rsp_data.new_pos_x == -$signed({1'b0, half_x_ff})))
      else $error("x wall hit without clamp");
`endif

endmodule
